### hw/rtl/trf_pkg.sv
// ----------------------------------------------------------------------------
// trf_pkg
// Shared types and constants for the TLV record finder.
// ----------------------------------------------------------------------------
package trf_pkg;

   // Bytes in a record header: type low/high, length low/high
   localparam int unsigned HDR_BYTES = 4;

   // Result queue depth; two free slots are needed to take a transaction
   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_AW    = $clog2(RSP_DEPTH);

   typedef enum logic [2:0] {
      PH_TYPE_LO  = 3'd0,
      PH_TYPE_HI  = 3'd1,
      PH_LEN_LO   = 3'd2,
      PH_LEN_HI   = 3'd3,
      PH_VALUE    = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_FOUND  = 2'd0,
      ST_ABSENT = 2'd1,
      ST_TRUNC  = 2'd2
   } status_type;

   localparam logic KIND_VALUE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] value_byte;
      logic [1:0] status;
      logic       last_result;
   } result_type;

endpackage

### hw/rtl/trf_if.sv
// ----------------------------------------------------------------------------
// trf_req_if / trf_rsp_if
// Valid/ready channels carrying payload bytes in and results out.
// ----------------------------------------------------------------------------
interface trf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       payload_end;

   modport source (output valid, output data_byte, output payload_end, input ready);
   modport sink   (input valid, input data_byte, input payload_end, output ready);
endinterface

interface trf_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] value_byte;
   logic [1:0] status;
   logic       last_result;

   modport source (output valid, output kind, output value_byte, output status,
                   output last_result, input ready);
   modport sink   (input valid, input kind, input value_byte, input status,
                   input last_result, output ready);
endinterface

### hw/rtl/tlv_record_finder_core.sv
// ----------------------------------------------------------------------------
// tlv_record_finder_core
// Extracts the value bytes of the first record of the configured type from a
// little-endian type/length/value byte stream and reports an end status.
// ----------------------------------------------------------------------------
// Throughput: one payload byte per cycle while the four-entry result queue
//   has two free slots; a byte giving two results is still taken at once and
//   the queue absorbs the extra result. Results are registered into the queue.
// Reset: synchronous; clears the parser state, the result queue and the
//   wanted type register (to zero).
module tlv_record_finder_core (
   input  logic             clock,
   input  logic             reset,
   trf_req_if.sink          req_if,
   trf_rsp_if.source        rsp_if,
   input  logic             csr_we,
   input  logic [15:0]      csr_wdata
);
   import trf_pkg::*;

   logic [15:0]      wanted_type_ff;
   phase_type        phase_ff, phase_in;
   logic [7:0]       type_low_ff, type_low_in;
   logic [7:0]       length_low_ff, length_low_in;
   logic [15:0]      bytes_left_ff, bytes_left_in;
   logic             in_match_ff, in_match_in;
   logic             found_done_ff, found_done_in;

   result_type       queue_ff [RSP_DEPTH];
   logic [RSP_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_AW:0]   count_ff, count_in;

   logic             req_take, rsp_take;
   logic             emit_value;
   logic [15:0]      length_word;
   status_type       end_status;
   result_type       value_res, status_res, first_res;
   logic [1:0]       push_n;
   logic [RSP_AW-1:0] wr_ptr_nxt;

   assign req_take    = req_if.valid && req_if.ready;
   assign rsp_take    = rsp_if.valid && rsp_if.ready;
   assign length_word = {req_if.data_byte, length_low_ff};

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (!found_done_ff) begin
         case (phase_ff)
            PH_TYPE_HI: phase_in = PH_LEN_LO;
            PH_LEN_LO:  phase_in = PH_LEN_HI;
            PH_LEN_HI:  phase_in = (length_word == 16'd0) ? PH_TYPE_LO : PH_VALUE;
            PH_VALUE:   phase_in = (bytes_left_ff == 16'd1) ? PH_TYPE_LO : PH_VALUE;
            default:    phase_in = PH_TYPE_HI;
         endcase
      end
   end

   // Datapath updates and results
   always_comb begin
      type_low_in   = type_low_ff;
      length_low_in = length_low_ff;
      bytes_left_in = bytes_left_ff;
      in_match_in   = in_match_ff;
      found_done_in = found_done_ff;
      emit_value    = 1'b0;
      if (!found_done_ff) begin
         case (phase_ff)
            PH_TYPE_HI: in_match_in = ({req_if.data_byte, type_low_ff} == wanted_type_ff);
            PH_LEN_LO:  length_low_in = req_if.data_byte;
            PH_LEN_HI: begin
               if (length_word == 16'd0) begin
                  found_done_in = in_match_ff;
               end else begin
                  bytes_left_in = length_word;
               end
            end
            PH_VALUE: begin
               emit_value    = in_match_ff;
               bytes_left_in = bytes_left_ff - 16'd1;
               if (bytes_left_ff == 16'd1) begin
                  found_done_in = in_match_ff;
               end
            end
            default:    type_low_in = req_if.data_byte;
         endcase
      end

      if (found_done_in) begin
         end_status = ST_FOUND;
      end else if (phase_in == PH_VALUE) begin
         end_status = ST_TRUNC;
      end else begin
         end_status = ST_ABSENT;
      end

      value_res.kind         = KIND_VALUE;
      value_res.value_byte   = req_if.data_byte;
      value_res.status       = ST_FOUND;
      value_res.last_result  = 1'b0;
      status_res.kind        = KIND_STATUS;
      status_res.value_byte  = 8'd0;
      status_res.status      = end_status;
      status_res.last_result = 1'b1;
      first_res              = emit_value ? value_res : status_res;
      push_n = req_take ? (2'(emit_value) + 2'(req_if.payload_end)) : 2'd0;
   end

   assign wr_ptr_nxt = wr_ptr_ff + RSP_AW'(1);
   assign count_in   = count_ff + (RSP_AW+1)'(push_n) - (RSP_AW+1)'(rsp_take);

   assign req_if.ready       = (count_ff <= (RSP_AW+1)'(RSP_DEPTH - 2));
   assign rsp_if.valid       = (count_ff != '0);
   assign rsp_if.kind        = queue_ff[rd_ptr_ff].kind;
   assign rsp_if.value_byte  = queue_ff[rd_ptr_ff].value_byte;
   assign rsp_if.status      = queue_ff[rd_ptr_ff].status;
   assign rsp_if.last_result = queue_ff[rd_ptr_ff].last_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_type_ff <= 16'd0;
         phase_ff       <= PH_TYPE_LO;
         type_low_ff    <= 8'd0;
         length_low_ff  <= 8'd0;
         bytes_left_ff  <= 16'd0;
         in_match_ff    <= 1'b0;
         found_done_ff  <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         if (csr_we) begin
            wanted_type_ff <= csr_wdata;
         end
         if (req_take) begin
            if (req_if.payload_end) begin
               // drop all record state once the end status is queued
               phase_ff      <= PH_TYPE_LO;
               type_low_ff   <= 8'd0;
               length_low_ff <= 8'd0;
               bytes_left_ff <= 16'd0;
               in_match_ff   <= 1'b0;
               found_done_ff <= 1'b0;
            end else begin
               phase_ff      <= phase_in;
               type_low_ff   <= type_low_in;
               length_low_ff <= length_low_in;
               bytes_left_ff <= bytes_left_in;
               in_match_ff   <= in_match_in;
               found_done_ff <= found_done_in;
            end
         end
         wr_ptr_ff <= wr_ptr_ff + RSP_AW'(push_n);
         if (rsp_take) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_AW'(1);
         end
         count_ff <= count_in;
      end
   end

   // Result queue storage; a value byte goes ahead of its end status
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= first_res;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_nxt] <= status_res;
      end
   end

endmodule

### dv/tlv_record_finder_core_tb.sv
// ----------------------------------------------------------------------------
// tlv_record_finder_core_tb
// Streams payloads of little-endian type/length/value records through the
// record finder, several wanted types in turn, and checks every value byte
// and end status against a cycle-free model of the parser.
// ----------------------------------------------------------------------------
module tlv_record_finder_core_tb;
   import trf_pkg::*;

   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_BYTES    = 145;
   localparam int MAX_REPORTS    = 10;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } payload_byte_type;

   typedef enum int {RX_OPEN, RX_LOSSY, RX_SPARSE, RX_COIN} rx_pattern_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [15:0] csr_wdata;

   trf_req_if req ();
   trf_rsp_if rsp ();

   tlv_record_finder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req),
      .rsp_if    (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // stimulus and scoreboard storage
   payload_byte_type pending_bytes[$];
   logic [7:0]       payload_buf[$];
   result_type       expected_results[$];

   int bytes_queued   = 0;
   int bytes_taken    = 0;
   int payload_count  = 0;
   int value_bytes    = 0;
   int status_tally[3] = '{0, 0, 0};
   int mismatch_count = 0;
   int results_seen   = 0;

   // parser model state
   logic [15:0] wanted_copy = 16'h0000;
   phase_type   parse_phase = PH_TYPE_LO;
   logic [7:0]  type_low    = 8'h00;
   logic [7:0]  len_low     = 8'h00;
   logic [15:0] bytes_left  = 16'h0000;
   logic        in_match    = 1'b0;
   logic        found_done  = 1'b0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Parser model: work out the results one accepted byte causes
   // ------------------------------------------------------------------------
   task automatic predict_byte(input logic [7:0] b, input logic fin);
      logic [15:0] field;
      status_type  end_status;
      begin
         if (!found_done) begin
            case (parse_phase)
               PH_TYPE_HI: begin
                  field       = {b, type_low};
                  in_match    = (field == wanted_copy);
                  parse_phase = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  len_low     = b;
                  parse_phase = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  field = {b, len_low};
                  if (field == 16'h0000) begin
                     if (in_match) found_done = 1'b1;
                     parse_phase = PH_TYPE_LO;
                  end else begin
                     bytes_left  = field;
                     parse_phase = PH_VALUE;
                  end
               end
               PH_VALUE: begin
                  if (in_match) begin
                     expected_results.insert(expected_results.size(),
                                             '{kind: KIND_VALUE, value_byte: b,
                                               status: ST_FOUND, last_result: 1'b0});
                     value_bytes++;
                  end
                  bytes_left = bytes_left - 16'd1;
                  if (bytes_left == 16'h0000) begin
                     if (in_match) found_done = 1'b1;
                     parse_phase = PH_TYPE_LO;
                  end
               end
               default: begin
                  type_low    = b;
                  parse_phase = PH_TYPE_HI;
               end
            endcase
         end
         if (fin) begin
            if (found_done)                end_status = ST_FOUND;
            else if (parse_phase == PH_VALUE) end_status = ST_TRUNC;
            else                           end_status = ST_ABSENT;
            expected_results.insert(expected_results.size(),
                                    '{kind: KIND_STATUS, value_byte: 8'h00,
                                      status: end_status, last_result: 1'b1});
            status_tally[end_status]++;
            parse_phase = PH_TYPE_LO;
            type_low    = 8'h00;
            len_low     = 8'h00;
            bytes_left  = 16'h0000;
            in_match    = 1'b0;
            found_done  = 1'b0;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Payload construction
   // ------------------------------------------------------------------------
   task automatic send_payload();
      begin
         foreach (payload_buf[i])
            pending_bytes.insert(pending_bytes.size(),
                                 '{data: payload_buf[i],
                                   last: (i == payload_buf.size() - 1)});
         bytes_queued += payload_buf.size();
         payload_count++;
         payload_buf.delete();
      end
   endtask

   task automatic add_header(input logic [15:0] rec_type, input logic [15:0] rec_len);
      begin
         payload_buf.insert(payload_buf.size(), rec_type[7:0]);
         payload_buf.insert(payload_buf.size(), rec_type[15:8]);
         payload_buf.insert(payload_buf.size(), rec_len[7:0]);
         payload_buf.insert(payload_buf.size(), rec_len[15:8]);
      end
   endtask

   // half the time the wanted type, some near misses one bit off, the rest anything
   function automatic logic [15:0] pick_type();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) return wanted_copy;
      if (sel < 7) return wanted_copy ^ (16'h0001 << $urandom_range(0, 15));
      return 16'($urandom);
   endfunction

   task automatic random_payload();
      int          n_rec;
      int          shape;
      int          len;
      int          sent;
      logic [15:0] rec_type;
      begin
         n_rec = $urandom_range(0, 4);
         shape = $urandom_range(0, 9);
         if (shape == 0) begin
            // noise: bytes with no structure in mind
            repeat ($urandom_range(1, 12))
               payload_buf.insert(payload_buf.size(), 8'($urandom));
         end else begin
            repeat (n_rec) begin
               rec_type = pick_type();
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40)
                                                 : $urandom_range(0, 6);
               add_header(rec_type, 16'(len));
               repeat (len) payload_buf.insert(payload_buf.size(), 8'($urandom));
            end
            if (shape <= 2) begin
               // header fragment at the tail
               repeat ($urandom_range(1, 3))
                  payload_buf.insert(payload_buf.size(), 8'($urandom));
            end else if (shape <= 4) begin
               // record whose value runs past the end
               rec_type = pick_type();
               len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                 : $urandom_range(1, 12);
               add_header(rec_type, 16'(len));
               sent = $urandom_range(0, (len < 9) ? len - 1 : 8);
               repeat (sent) payload_buf.insert(payload_buf.size(), 8'($urandom));
            end
            if (payload_buf.size() == 0)
               payload_buf.insert(payload_buf.size(), 8'($urandom));
         end
         send_payload();
      end
   endtask

   // hold until every byte is taken and every result has arrived
   task automatic wait_drained();
      begin
         while (!(bytes_taken == bytes_queued && expected_results.size() == 0))
            @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end
   endtask

   task automatic write_wanted_type(input logic [15:0] value);
      begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_wdata <= value;
         @(posedge clock);
         csr_we    <= 1'b0;
         wanted_copy = value;
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: bursts of transactions with random gaps
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_bytes
      payload_byte_type item;
      logic             next_valid;
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            predict_byte(req.data_byte, req.payload_end);
            bytes_taken++;
         end
         if (!req.valid || req.ready) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_bytes.size() > 0) begin
               item = pending_bytes.pop_front();
               req.data_byte   <= item.data;
               req.payload_end <= item.last;
               next_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                           : $urandom_range(0, 8);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
            req.valid <= next_valid;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: compare each result transaction, stall on a shifting pattern
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input result_type want,
                                  input result_type got);
      begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $write("ERROR: %s: expected kind=%0d value=%02h status=%0d last=%0d, ",
                   what, want.kind, want.value_byte, want.status, want.last_result);
            $display("got kind=%0d value=%02h status=%0d last=%0d",
                     got.kind, got.value_byte, got.status, got.last_result);
         end
      end
   endtask

   rx_pattern_type rx_pattern = RX_OPEN;
   int             rx_tick    = 0;
   int             rx_span    = 64;

   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = '{kind: rsp.kind, value_byte: rsp.value_byte,
                    status: rsp.status, last_result: rsp.last_result};
            results_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing pending", '0, got);
            end else begin
               want = expected_results.pop_front();
               if (got.kind !== want.kind || got.value_byte !== want.value_byte ||
                   got.status !== want.status || got.last_result !== want.last_result)
                  report_mismatch("result mismatch", want, got);
            end
         end
         rx_tick++;
         if (rx_tick >= rx_span) begin
            rx_pattern = rx_pattern_type'($urandom_range(0, 3));
            rx_span    = $urandom_range(32, 256);
            rx_tick    = 0;
         end
         case (rx_pattern)
            RX_OPEN:   rsp.ready <= 1'b1;
            RX_LOSSY:  rsp.ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: rsp.ready <= ((rx_tick % 9) < 2);
            default:   rsp.ready <= ($urandom_range(0, 1) == 1);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: end the run if traffic stops
   // ------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin : watchdog
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_we) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, expected_results.size());
            $display("tlv_record_finder_core test failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus sequence
   // ------------------------------------------------------------------------
   initial begin : run_test
      logic [15:0] wanted_list[9];
      int          phase_start;
      req.valid       = 1'b0;
      req.data_byte   = 8'h00;
      req.payload_end = 1'b0;
      rsp.ready       = 1'b0;
      csr_we          = 1'b0;
      csr_wdata       = 16'h0000;
      reset           = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed payloads against the reset wanted type of zero
      payload_buf = '{8'h00, 8'h00, 8'h01, 8'h00, 8'hFF};           // match, one value byte
      send_payload();
      payload_buf = '{8'h00, 8'h00, 8'h00, 8'h00};                  // zero-length match
      send_payload();
      payload_buf = '{8'h7F};                                       // lone header fragment
      send_payload();
      payload_buf = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00};           // value and truncation together
      send_payload();
      // miss, then empty match, then a byte after the match that must be ignored
      payload_buf = '{8'hFF, 8'hFF, 8'h01, 8'h00, 8'h55,
                      8'h00, 8'h00, 8'h00, 8'h00, 8'h33};
      send_payload();
      wait_drained();

      wanted_list = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h8000, 16'($urandom),
                      16'h00FF, 16'($urandom), 16'h0001, 16'($urandom)};
      foreach (wanted_list[p]) begin
         write_wanted_type(wanted_list[p]);
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < PHASE_BYTES) random_payload();
         wait_drained();
      end

      $display("Ran %0d payloads (%0d bytes) over %0d wanted types; %0d results checked",
               payload_count, bytes_queued, $size(wanted_list) + 1, results_seen);
      $display("Extracted %0d value bytes; end status found %0d, absent %0d, truncated %0d",
               value_bytes, status_tally[ST_FOUND], status_tally[ST_ABSENT],
               status_tally[ST_TRUNC]);
      if (mismatch_count == 0) begin
         $display("tlv_record_finder_core test passed");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("tlv_record_finder_core test failed");
      end
      $finish;
   end

endmodule

### tlv_record_finder_core.f
hw/rtl/trf_pkg.sv
hw/rtl/trf_if.sv
hw/rtl/tlv_record_finder_core.sv
dv/tlv_record_finder_core_tb.sv
